// File: rtl/pltc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pltc_pkg
// Shared types and constants for the piecewise linear tone curve block.
// ----------------------------------------------------------------------------
package pltc_pkg;

  // Knot count default and sample width
  localparam int KNOT_COUNT_DEF = 6;
  localparam int SAMPLE_W       = 8;

  // Quotient bits, one per divider step; sum of the weighted levels
  localparam int QUOT_BITS = SAMPLE_W;
  localparam int SUM_W     = 2 * SAMPLE_W;

  // Pipeline: search stage, multiply stage, then one stage per quotient bit
  localparam int PIPE_DEPTH = 2 + QUOT_BITS;

  // APB port widths: 64-bit data, registers at byte address 8*i
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;

  // Reset curves (cool), knot k in bits 8k+7..8k
  localparam logic [DATA_W-1:0] RESET_KNOTS = 64'd281236981690880;
  localparam logic [DATA_W-1:0] RESET_RED   = 64'd281020971095040;
  localparam logic [DATA_W-1:0] RESET_BLUE  = 64'd281323555409920;

  // Register indexes
  typedef enum logic [1:0] {
    REG_KNOTS = 2'd0,
    REG_RED   = 2'd1,
    REG_BLUE  = 2'd2
  } cfg_reg_t;

endpackage

// File: rtl/pltc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pltc_div
// Pipelined restoring divider: one quotient bit per stage, each stage
// registered and advanced by its own load strobe.
// ----------------------------------------------------------------------------
module pltc_div (
  input  logic                          clk,
  input  logic [pltc_pkg::QUOT_BITS-1:0] load,
  input  logic [pltc_pkg::SUM_W-1:0]     sum,
  input  logic [pltc_pkg::SAMPLE_W-1:0]  dx,
  output logic [pltc_pkg::QUOT_BITS-1:0] quot
);
  import pltc_pkg::*;

  logic [SUM_W-1:0]     rem_q [QUOT_BITS];
  logic [SAMPLE_W-1:0]  dx_q  [QUOT_BITS];
  logic [QUOT_BITS-1:0] quo_q [QUOT_BITS];

  genvar k;
  generate
    for (k = 0; k < QUOT_BITS; k++) begin : g_step
      logic [SUM_W-1:0]     rem_in;
      logic [SAMPLE_W-1:0]  dx_in;
      logic [QUOT_BITS-1:0] quo_in;
      logic [SUM_W:0]       dsh;
      logic [SUM_W:0]       trial;
      logic                 qbit;
      logic [SUM_W-1:0]     rem_next;

      // Pick up the previous step
      if (k == 0) begin : g_first
        assign rem_in = sum;
        assign dx_in  = dx;
        assign quo_in = '0;
      end else begin : g_rest
        assign rem_in = rem_q[k-1];
        assign dx_in  = dx_q[k-1];
        assign quo_in = quo_q[k-1];
      end

      // Trial subtract of the shifted divisor
      assign dsh      = (SUM_W+1)'(dx_in) << (QUOT_BITS - 1 - k);
      assign trial    = {1'b0, rem_in} - dsh;
      assign qbit     = ~trial[SUM_W];
      assign rem_next = qbit ? trial[SUM_W-1:0] : rem_in;

      always_ff @(posedge clk) begin
        if (load[k]) begin
          rem_q[k] <= rem_next;
          dx_q[k]  <= dx_in;
          quo_q[k] <= {quo_in[QUOT_BITS-2:0], qbit};
        end
      end
    end
  endgenerate

  assign quot = quo_q[QUOT_BITS-1];

endmodule

// File: rtl/pltc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pltc_lane
// One curve lane: knot search, weighted sum of the two bracketing levels,
// and the divider that scales the sum by the segment width.
// ----------------------------------------------------------------------------
module pltc_lane #(
  parameter int KNOT_COUNT = pltc_pkg::KNOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic [pltc_pkg::PIPE_DEPTH-1:0] load,
  input  logic [pltc_pkg::SAMPLE_W-1:0]   sample,
  input  logic [8*KNOT_COUNT-1:0]         knots,
  input  logic [8*KNOT_COUNT-1:0]         levels,
  output logic [pltc_pkg::SAMPLE_W-1:0]   mapped
);
  import pltc_pkg::*;

  logic [SAMPLE_W-1:0] xk    [KNOT_COUNT];
  logic [SAMPLE_W-1:0] yk    [KNOT_COUNT];
  logic [SAMPLE_W-1:0] xprev [KNOT_COUNT];
  logic [SAMPLE_W-1:0] yprev [KNOT_COUNT];

  // Unpack knots and the level of the knot below each one
  genvar g;
  generate
    for (g = 0; g < KNOT_COUNT; g++) begin : g_knot
      assign xk[g] = knots[8*g +: 8];
      assign yk[g] = levels[8*g +: 8];
      if (g == 0) begin : g_lo
        assign xprev[g] = '0;
        assign yprev[g] = '0;
      end else begin : g_hi
        assign xprev[g] = knots[8*(g-1) +: 8];
        assign yprev[g] = levels[8*(g-1) +: 8];
      end
    end
  endgenerate

  // Search: first knot at or above the sample wins
  logic                found;
  logic                first;
  logic [SAMPLE_W-1:0] xj, yj, xp, yp;
  logic [SAMPLE_W-1:0] yp_next, yj_next, dx_next, t_next;

  always_comb begin
    found = 1'b0;
    first = 1'b0;
    xj    = '0;
    yj    = yk[KNOT_COUNT-1];
    xp    = '0;
    yp    = '0;
    for (int k = KNOT_COUNT - 1; k >= 0; k--) begin
      if (sample <= xk[k]) begin
        found = 1'b1;
        first = (k == 0);
        xj    = xk[k];
        yj    = yk[k];
        xp    = xprev[k];
        yp    = yprev[k];
      end
    end
  end

  // Direct cases go through the divider as y * 1 / 1
  always_comb begin
    if (!found || first || (xj == sample)) begin
      yp_next = yj;
      yj_next = yj;
      dx_next = SAMPLE_W'(1);
      t_next  = '0;
    end else begin
      yp_next = yp;
      yj_next = yj;
      dx_next = xj - xp;
      t_next  = sample - xp;
    end
  end

  // Search stage registers
  logic [SAMPLE_W-1:0] yp0, yj0, dx0, t0;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      yp0 <= yp_next;
      yj0 <= yj_next;
      dx0 <= dx_next;
      t0  <= t_next;
    end
  end

  // Weighted sum: yp*(dx-t) + yj*t, never above 255*dx
  logic [SAMPLE_W-1:0] dx_m_t;
  logic [SUM_W-1:0]    prod_a, prod_b;
  logic [SUM_W-1:0]    sum1;
  logic [SAMPLE_W-1:0] dx1;

  assign dx_m_t = dx0 - t0;
  assign prod_a = {{SAMPLE_W{1'b0}}, yp0} * {{SAMPLE_W{1'b0}}, dx_m_t};
  assign prod_b = {{SAMPLE_W{1'b0}}, yj0} * {{SAMPLE_W{1'b0}}, t0};

  always_ff @(posedge clk) begin
    if (load[1]) begin
      sum1 <= prod_a + prod_b;
      dx1  <= dx0;
    end
  end

  // Scale by the segment width
  pltc_div u_div (
    .clk  (clk),
    .load (load[PIPE_DEPTH-1:2]),
    .sum  (sum1),
    .dx   (dx1),
    .quot (mapped)
  );

endmodule

// File: rtl/piecewise_linear_tone_curve_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_tone_curve_top
// BGR tone curve: blue and red through their own piecewise linear curves,
// green passed through, knots and levels set over an APB-style port.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output is not stalled. Each
// pixel passes through the knot search register, the weighted sum register
// for the two bracketing levels, and eight pipelined divider stages that
// yield one quotient bit per stage. Blue and red run in two identical lanes
// and green rides a matching delay line. Each stage moves on its own when the
// next one has room, so bubbles squeeze out while the output is stalled.
// Registers sit at byte addresses 0 (knot positions), 8 (red levels) and
// 16 (blue levels); write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
module piecewise_linear_tone_curve_top #(
  parameter int KNOT_COUNT = pltc_pkg::KNOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pltc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pltc_pkg::DATA_W-1:0]   pwdata,
  output logic [pltc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Pixel in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pltc_pkg::SAMPLE_W-1:0] blue_in,
  input  logic [pltc_pkg::SAMPLE_W-1:0] green_in,
  input  logic [pltc_pkg::SAMPLE_W-1:0] red_in,
  // Pixel out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pltc_pkg::SAMPLE_W-1:0] blue_out,
  output logic [pltc_pkg::SAMPLE_W-1:0] green_out,
  output logic [pltc_pkg::SAMPLE_W-1:0] red_out
);
  import pltc_pkg::*;

  localparam int REG_W = 8 * KNOT_COUNT;

  // Configuration registers
  logic [REG_W-1:0] knot_positions;
  logic [REG_W-1:0] red_levels;
  logic [REG_W-1:0] blue_levels;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_positions <= RESET_KNOTS[REG_W-1:0];
      red_levels     <= RESET_RED[REG_W-1:0];
      blue_levels    <= RESET_BLUE[REG_W-1:0];
    end else if (cfg_write) begin
      unique case (paddr[ADDR_W-1:3])
        REG_KNOTS: knot_positions <= pwdata[REG_W-1:0];
        REG_RED:   red_levels     <= pwdata[REG_W-1:0];
        REG_BLUE:  blue_levels    <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[ADDR_W-1:3])
      REG_KNOTS: prdata = DATA_W'(knot_positions);
      REG_RED:   prdata = DATA_W'(red_levels);
      REG_BLUE:  prdata = DATA_W'(blue_levels);
      default:   prdata = '0;
    endcase
  end

  // Stage loads: a stage takes a word when it is empty or its own word moves on
  logic [PIPE_DEPTH-1:0] valid;
  logic [PIPE_DEPTH-1:0] load;

  always_comb begin
    load[PIPE_DEPTH-1] = ~valid[PIPE_DEPTH-1] | ~out_stall;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      load[i] = ~valid[i] | load[i+1];
    end
  end

  assign in_stall = ~load[0];

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Green delay line
  logic [SAMPLE_W-1:0] green_pipe [PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      green_pipe[0] <= green_in;
    end
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      if (load[i]) begin
        green_pipe[i] <= green_pipe[i-1];
      end
    end
  end

  // Curve lanes
  pltc_lane #(
    .KNOT_COUNT (KNOT_COUNT)
  ) u_blue (
    .clk    (clk),
    .load   (load),
    .sample (blue_in),
    .knots  (knot_positions),
    .levels (blue_levels),
    .mapped (blue_out)
  );

  pltc_lane #(
    .KNOT_COUNT (KNOT_COUNT)
  ) u_red (
    .clk    (clk),
    .load   (load),
    .sample (red_in),
    .knots  (knot_positions),
    .levels (red_levels),
    .mapped (red_out)
  );

  // Merge lanes with the green sample
  assign green_out = green_pipe[PIPE_DEPTH-1];
  assign out_valid = valid[PIPE_DEPTH-1];

endmodule

// File: rtl/pltc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pltc_checker
// Port-level checks on the tone curve block, bound to the top level.
// ----------------------------------------------------------------------------
module pltc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pltc_pkg::SAMPLE_W-1:0] blue_out,
  input logic [pltc_pkg::SAMPLE_W-1:0] green_out,
  input logic [pltc_pkg::SAMPLE_W-1:0] red_out
);
  import pltc_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present right after reset");

  // Input is only held back by a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output stage can move");

  // A stalled word stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output word dropped");

  // A stalled word does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      ($stable(blue_out) && $stable(green_out) && $stable(red_out)))
    else $error("stalled output word changed");

endmodule

bind piecewise_linear_tone_curve_top pltc_checker u_pltc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .blue_out  (blue_out),
  .green_out (green_out),
  .red_out   (red_out)
);

// File: sim/tb_piecewise_linear_tone_curve_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_tone_curve_top
// Self-checking regression for the BGR tone curve block. Pixels are pushed
// through the valid/stall input while the output side stalls at random. Each
// accepted pixel is mapped by a local curve predictor and checked against the
// returned word. The curves are reprogrammed over the APB port between phases:
// reset (cool), warm, degenerate knot sets and random curves.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_tone_curve_top;
  import pltc_pkg::*;

  localparam int KNOTS      = KNOT_COUNT_DEF;
  localparam int CURVE_W    = 8 * KNOTS;
  localparam int QUIET_MAX  = 2000;
  localparam int REG_NONE   = 3;
  localparam int DRAIN_WAIT = PIPE_DEPTH + 6;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Clock, reset and block ports
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [7:0]        blue_in   = '0;
  logic [7:0]        green_in  = '0;
  logic [7:0]        red_in    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        blue_out;
  logic [7:0]        green_out;
  logic [7:0]        red_out;

  // Local copy of the curve registers
  logic [CURVE_W-1:0] knots_cfg = RESET_KNOTS[CURVE_W-1:0];
  logic [CURVE_W-1:0] red_cfg   = RESET_RED[CURVE_W-1:0];
  logic [CURVE_W-1:0] blue_cfg  = RESET_BLUE[CURVE_W-1:0];

  pixel_t expected_pixels[$];
  pixel_t want;
  int     errors      = 0;
  int     pixels_sent = 0;
  int     cfg_writes  = 0;
  bit     idle_on     = 1'b1;
  int     stall_left  = 0;

  piecewise_linear_tone_curve_top #(
    .KNOT_COUNT(KNOTS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .blue_in  (blue_in),
    .green_in (green_in),
    .red_in   (red_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .blue_out (blue_out),
    .green_out(green_out),
    .red_out  (red_out)
  );

  always #5 clk = ~clk;

  // Map one sample through a curve: first knot at or above v, exact hit,
  // clamp below the first and above the last knot, else floor interpolation
  function automatic logic [7:0] tone_map(logic [7:0] v, logic [CURVE_W-1:0] xs,
                                          logic [CURVE_W-1:0] ys);
    int j, xj, xp, yj, yp, dx, t;
    bit found;
    j = KNOTS;
    found = 1'b0;
    for (int k = 0; k < KNOTS; k++) begin
      if (!found && v <= xs[8*k +: 8]) begin
        j = k;
        found = 1'b1;
      end
    end
    if (j == KNOTS) return ys[8*(KNOTS-1) +: 8];
    xj = int'(xs[8*j +: 8]);
    yj = int'(ys[8*j +: 8]);
    if (xj == int'(v) || j == 0) return 8'(yj);
    xp = int'(xs[8*(j-1) +: 8]);
    yp = int'(ys[8*(j-1) +: 8]);
    dx = xj - xp;
    t  = int'(v) - xp;
    return 8'(((yp * (dx - t) + yj * t) / dx) & 255);
  endfunction

  // Bias samples toward the knots and the range ends
  function automatic logic [7:0] pick_sample();
    int sel, k, v;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 8'($urandom_range(0, 255));
    if (sel < 8) begin
      k = $urandom_range(0, KNOTS - 1);
      v = int'(knots_cfg[8*k +: 8]) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
    end
    return (sel == 8) ? 8'd0 : 8'd255;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rand_gap();
    if (!idle_on || $urandom_range(0, 99) < 65) return 0;
    return idle_len();
  endfunction

  // Strictly increasing knot positions, sometimes pinned to 0 and 255
  function automatic logic [CURVE_W-1:0] rand_sorted_knots();
    logic [CURVE_W-1:0] xs;
    int prev, rem, hi, x;
    bit pin;
    pin = ($urandom_range(0, 1) == 1);
    prev = -1;
    for (int k = 0; k < KNOTS; k++) begin
      rem = KNOTS - 1 - k;
      hi = prev + 1 + 2 * ((255 - rem - prev) / (rem + 1));
      if (hi > 255 - rem) hi = 255 - rem;
      x = $urandom_range(prev + 1, hi);
      if (pin && k == 0) x = 0;
      if (pin && k == KNOTS - 1) x = 255;
      xs[8*k +: 8] = 8'(x);
      prev = x;
    end
    return xs;
  endfunction

  function automatic logic [CURVE_W-1:0] rand_curve();
    return CURVE_W'({$urandom, $urandom});
  endfunction

  // Output side: random stall bursts while idling is enabled
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 99) < 20) stall_left = idle_len();
      out_stall <= (stall_left > 0);
    end
  end

  // Check each returned word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: blue %0d green %0d red %0d", blue_out, green_out, red_out);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (blue_out !== want.blue) begin
          $error("blue_out mismatch: expected %0d, got %0d", want.blue, blue_out);
          errors++;
        end
        if (green_out !== want.green) begin
          $error("green_out mismatch: expected %0d, got %0d", want.green, green_out);
          errors++;
        end
        if (red_out !== want.red) begin
          $error("red_out mismatch: expected %0d, got %0d", want.red, red_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles, %0d pixels outstanding",
             quiet, expected_pixels.size());
    $display("piecewise_linear_tone_curve_top regression: fail");
    $finish;
  end

  // Send one pixel word and record its mapped result at acceptance
  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int gap;
    pixel_t p;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    blue_in  <= b;
    green_in <= g;
    red_in   <= r;
    do @(posedge clk); while (!(in_valid && !in_stall));
    p.blue  = tone_map(b, knots_cfg, blue_cfg);
    p.green = g;
    p.red   = tone_map(r, knots_cfg, red_cfg);
    expected_pixels.push_back(p);
    pixels_sent++;
  endtask

  task automatic send_random(int n);
    repeat (n) send_pixel(pick_sample(), 8'($urandom), pick_sample());
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(int idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == int'(REG_KNOTS)) knots_cfg = value[CURVE_W-1:0];
    else if (idx == int'(REG_RED)) red_cfg = value[CURVE_W-1:0];
    else if (idx == int'(REG_BLUE)) blue_cfg = value[CURVE_W-1:0];
    cfg_writes++;
  endtask

  // Program all three curves, with junk in the unused upper bits
  task automatic load_curves(logic [CURVE_W-1:0] xs, logic [CURVE_W-1:0] rs,
                             logic [CURVE_W-1:0] bs);
    drain();
    cfg_write(int'(REG_KNOTS), {(DATA_W-CURVE_W)'($urandom), xs});
    cfg_write(int'(REG_RED),   {(DATA_W-CURVE_W)'($urandom), rs});
    cfg_write(int'(REG_BLUE),  {(DATA_W-CURVE_W)'($urandom), bs});
  endtask

  // Reset curves: range ends, knot hits and their neighbors
  task automatic test_reset_curves();
    logic [7:0] probe [16];
    probe = '{8'd0, 8'd1, 8'd49, 8'd50, 8'd51, 8'd99, 8'd100, 8'd101,
              8'd149, 8'd150, 8'd151, 8'd199, 8'd200, 8'd201, 8'd254, 8'd255};
    idle_on = 1'b1;
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_pixel(probe[i], 8'h00, probe[(i + 5) % 16]);
        1: send_pixel(probe[i], 8'hFF, probe[(i + 5) % 16]);
        2: send_pixel(probe[i], 8'h55, probe[(i + 5) % 16]);
        default: send_pixel(probe[i], 8'hAA, probe[(i + 5) % 16]);
      endcase
    end
    send_random(4);
  endtask

  // Warm curves: red and blue levels swapped; first a run with no idling
  task automatic test_warm_curves();
    drain();
    cfg_write(int'(REG_RED), RESET_BLUE);
    cfg_write(int'(REG_BLUE), RESET_RED);
    idle_on = 1'b0;
    send_random(60);
    idle_on = 1'b1;
    send_random(30);
  endtask

  // Degenerate knot sets, steep slopes and unordered knots
  task automatic test_degenerate_curves();
    idle_on = 1'b1;
    // all knots at zero: only v == 0 hits, everything else is above the last
    load_curves('0, {CURVE_W{1'b1}}, rand_curve());
    send_random(25);
    // all knots at 255: everything below the first except 255 itself
    load_curves({CURVE_W{1'b1}}, rand_curve(), '0);
    send_random(25);
    // segments two codes wide with alternating full-scale levels
    load_curves({8'd255, 8'd8, 8'd6, 8'd4, 8'd2, 8'd0},
                {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF},
                {8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
    send_random(25);
    // unordered and repeated knots follow the first-match scan
    load_curves(rand_curve(), rand_curve(), rand_curve());
    send_random(25);
    load_curves({8'd90, 8'd90, 8'd200, 8'd30, 8'd30, 8'd120},
                rand_curve(), rand_curve());
    send_random(25);
    // write to an unmapped index must leave the curves alone
    drain();
    cfg_write(REG_NONE, {$urandom, $urandom});
    send_random(20);
  endtask

  // Random curves, mostly with well-formed knot sets
  task automatic test_random_curves();
    for (int phase = 0; phase < 8; phase++) begin
      load_curves((phase % 4 == 3) ? rand_curve() : rand_sorted_knots(),
                  rand_curve(), rand_curve());
      idle_on = ($urandom_range(0, 3) != 0);
      send_random(40);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_curves();
    test_warm_curves();
    test_degenerate_curves();
    test_random_curves();

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d predicted pixels never returned", expected_pixels.size());
      errors++;
    end

    $display("covered %0d pixels across %0d register writes", pixels_sent, cfg_writes);
    $display("curves: reset, warm, degenerate knots, unordered knots, random; %0d errors",
             errors);
    if (errors == 0) begin
      $display("piecewise_linear_tone_curve_top regression: pass");
    end else begin
      $display("piecewise_linear_tone_curve_top regression: fail");
    end
    $finish;
  end

endmodule
